>>> hw/rtl/krt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the keyed record table.
package krt_pkg;

	localparam int TABLE_DEPTH  = 32;
	localparam int RECORD_WIDTH = 64;
	localparam int IDX_W        = $clog2(TABLE_DEPTH);
	localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W        = 32;
	localparam int KIND_W       = 3;
	localparam int MAXC_W       = 6;
	localparam int STATUS_W     = 2;
	localparam int MAX_STREAM   = 32;

	localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GET    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SNAP   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	// Which result the datapath loads into the output register.
	typedef enum logic [2:0] {
		RES_OK_EMPTY = 3'd0,
		RES_FULL     = 3'd1,
		RES_NOTFOUND = 3'd2,
		RES_ADD      = 3'd3,
		RES_RD_ENTRY = 3'd4,
		RES_SNAP     = 3'd5
	} res_t;

	typedef struct packed {
		logic ld_op;
		logic rd_issue;
		logic rd_sel_last;
		logic idx_inc;
		logic cap_hit;
		logic wr_add;
		logic wr_upd;
		logic wr_move;
		logic used_dec;
		logic emit;
		res_t res;
	} krt_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              full;
		logic              scan_end;
		logic              match;
		logic              snap_zero;
		logic              snap_last;
		logic              out_free;
	} krt_sts_t;

endpackage

>>> hw/rtl/keyed_record_table.sv
// Top level of the keyed record table: controller, datapath and checks.
// The table holds up to 32 records under 32-bit identifiers handed out by a wrapping counter
// that starts at 1. One operation is in flight at a time: an item is taken and then decoded in
// the next cycle. Add and unknown kinds then load their result into the output register. Get,
// update and remove scan the slots through the single read port of the slot memory, one slot
// per cycle with the compare in the cycle after the read; remove then reads the last slot and
// moves it into the freed one. After decode, a snapshot reads the first slot and then
// streams one entry per cycle while the output register is free; an empty snapshot gives its
// result like an unknown kind. A finished result sits in an output register, so the next
// item is taken while it waits; the block stalls only when a new result meets a full output
// register. Slot memories are not cleared after reset; only slots below the entry count are read.
module keyed_record_table (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [krt_pkg::KIND_W-1:0]           kind,
	input  logic [krt_pkg::KEY_W-1:0]            key,
	input  logic [krt_pkg::RECORD_WIDTH-1:0]     record_in,
	input  logic [krt_pkg::MAXC_W-1:0]           max_count,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [krt_pkg::STATUS_W-1:0]         status,
	output logic [krt_pkg::KEY_W-1:0]            entry_key,
	output logic [krt_pkg::RECORD_WIDTH-1:0]     entry_data,
	output logic                                 entry_valid,
	output logic [krt_pkg::CNT_W-1:0]            copied_count,
	output logic                                 last
);
	import krt_pkg::*;

	krt_cmd_t cmd;
	krt_sts_t sts;

	krt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	krt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (kind),
		.key          (key),
		.record_in    (record_in),
		.max_count    (max_count),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.entry_key    (entry_key),
		.entry_data   (entry_data),
		.entry_valid  (entry_valid),
		.copied_count (copied_count),
		.last         (last)
	);

	// A result is loaded only when the output register is empty or being drained.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result loaded over a pending output transfer");

	// Once a transfer is taken the block is busy on it in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice without processing");

	// No slot is written while the block waits for input.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.wr_add || cmd.wr_upd || cmd.wr_move))
		else $error("slot memory written while idle");

	// An add never writes into a full table.
	a_add_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_add |-> !sts.full)
		else $error("add written into a full table");

endmodule

>>> hw/rtl/krt_ctrl.sv
// Controller state machine that sequences lookups, writes, removals and snapshot streaming.
module krt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  krt_pkg::krt_sts_t sts,
	output krt_pkg::krt_cmd_t cmd
);
	import krt_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DISPATCH = 9'b000000010,
		S_SCAN     = 9'b000000100,
		S_RM_RD    = 9'b000001000,
		S_RM_WR    = 9'b000010000,
		S_ADD      = 9'b000100000,
		S_SNAP     = 9'b001000000,
		S_SNAP_EM  = 9'b010000000,
		S_EMIT     = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	res_t   res_q, res_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_op = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.kind) inside
					KIND_ADD: state_d = S_ADD;
					KIND_GET, KIND_UPDATE, KIND_REMOVE: state_d = S_SCAN;
					KIND_SNAP: begin
						if (sts.snap_zero) begin
							res_d   = RES_OK_EMPTY;
							state_d = S_EMIT;
						end else begin
							state_d = S_SNAP;
						end
					end
					default: begin
						res_d   = RES_OK_EMPTY;
						state_d = S_EMIT;
					end
				endcase
			end
			S_SCAN: begin
				// The compare sees the slot read in the previous cycle while, short of a hit or the end, the next read goes out.
				if (sts.match) begin
					cmd.cap_hit = 1'b1;
					case (sts.kind)
						KIND_GET: begin
							res_d   = RES_RD_ENTRY;
							state_d = S_EMIT;
						end
						KIND_UPDATE: begin
							cmd.wr_upd = 1'b1;
							res_d      = RES_OK_EMPTY;
							state_d    = S_EMIT;
						end
						default: state_d = S_RM_RD;
					endcase
				end else if (sts.scan_end) begin
					res_d   = RES_NOTFOUND;
					state_d = S_EMIT;
				end else begin
					cmd.rd_issue = 1'b1;
					cmd.idx_inc  = 1'b1;
				end
			end
			S_RM_RD: begin
				cmd.rd_issue    = 1'b1;
				cmd.rd_sel_last = 1'b1;
				state_d         = S_RM_WR;
			end
			S_RM_WR: begin
				cmd.wr_move  = 1'b1;
				cmd.used_dec = 1'b1;
				res_d        = RES_OK_EMPTY;
				state_d      = S_EMIT;
			end
			S_ADD: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.full) begin
						cmd.res = RES_FULL;
					end else begin
						cmd.res    = RES_ADD;
						cmd.wr_add = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_SNAP: begin
				cmd.rd_issue = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_SNAP_EM;
			end
			S_SNAP_EM: begin
				// The next slot is read at the same edge that the current one moves out.
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.res  = RES_SNAP;
					if (sts.snap_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_issue = 1'b1;
						cmd.idx_inc  = 1'b1;
					end
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_OK_EMPTY;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

>>> hw/rtl/krt_dpath.sv
// Datapath: slot memories, counters, operation latch and the result output register.
module krt_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [krt_pkg::KIND_W-1:0]           kind,
	input  logic [krt_pkg::KEY_W-1:0]            key,
	input  logic [krt_pkg::RECORD_WIDTH-1:0]     record_in,
	input  logic [krt_pkg::MAXC_W-1:0]           max_count,
	input  krt_pkg::krt_cmd_t                    cmd,
	output krt_pkg::krt_sts_t                    sts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [krt_pkg::STATUS_W-1:0]         status,
	output logic [krt_pkg::KEY_W-1:0]            entry_key,
	output logic [krt_pkg::RECORD_WIDTH-1:0]     entry_data,
	output logic                                 entry_valid,
	output logic [krt_pkg::CNT_W-1:0]            copied_count,
	output logic                                 last
);
	import krt_pkg::*;

	logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
	logic [RECORD_WIDTH-1:0] data_mem [TABLE_DEPTH];

	logic [CNT_W-1:0]        used_q;
	logic [KEY_W-1:0]        next_key_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    pend_q;
	logic [IDX_W-1:0]        pend_idx_q;
	logic [IDX_W-1:0]        hit_idx_q;
	logic [KIND_W-1:0]       kind_q;
	logic [KEY_W-1:0]        key_q;
	logic [RECORD_WIDTH-1:0] rec_q;
	logic [CNT_W-1:0]        snap_n_q;
	logic [KEY_W-1:0]        rd_key_q;
	logic [RECORD_WIDTH-1:0] rd_data_q;
	logic                    out_valid_q;

	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        wr_addr;
	logic [RECORD_WIDTH-1:0] wr_data;
	logic [KEY_W-1:0]        wr_key;
	logic [MAXC_W-1:0]       maxc_sat;
	logic [CNT_W-1:0]        snap_n;

	logic [STATUS_W-1:0]     status_d;
	logic [KEY_W-1:0]        ekey_d;
	logic [RECORD_WIDTH-1:0] edata_d;
	logic                    evalid_d;
	logic [CNT_W-1:0]        ecnt_d;
	logic                    elast_d;

	assign rd_addr = cmd.rd_sel_last ? IDX_W'(used_q - CNT_W'(1)) : idx_q[IDX_W-1:0];

	always_comb begin
		wr_addr = used_q[IDX_W-1:0];
		wr_key  = next_key_q;
		wr_data = rec_q;
		if (cmd.wr_upd) begin
			wr_addr = pend_idx_q;
		end else if (cmd.wr_move) begin
			wr_addr = hit_idx_q;
			wr_key  = rd_key_q;
			wr_data = rd_data_q;
		end
	end

	// Snapshot length is fixed at accept time; the entry count cannot change during a snapshot.
	assign maxc_sat = (max_count > MAXC_W'(MAX_STREAM)) ? MAXC_W'(MAX_STREAM) : max_count;
	assign snap_n   = (CNT_W'(maxc_sat) < used_q) ? CNT_W'(maxc_sat) : used_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_add || cmd.wr_move) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (cmd.wr_add || cmd.wr_move || cmd.wr_upd) begin
			data_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_issue) begin
			rd_key_q  <= key_mem[rd_addr];
			rd_data_q <= data_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_op) begin
			kind_q   <= kind;
			key_q    <= key;
			rec_q    <= record_in;
			snap_n_q <= snap_n;
		end
		if (cmd.rd_issue) begin
			pend_idx_q <= rd_addr;
		end
		if (cmd.cap_hit) begin
			hit_idx_q <= pend_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			next_key_q <= KEY_W'(1);
			idx_q      <= '0;
			pend_q     <= 1'b0;
		end else begin
			if (cmd.wr_add) begin
				used_q     <= used_q + CNT_W'(1);
				next_key_q <= next_key_q + KEY_W'(1);
			end else if (cmd.used_dec) begin
				used_q <= used_q - CNT_W'(1);
			end
			if (cmd.ld_op) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				pend_q <= cmd.rd_issue;
			end
		end
	end

	assign sts.kind      = kind_q;
	assign sts.full      = (used_q == CNT_W'(TABLE_DEPTH));
	assign sts.scan_end  = (idx_q == used_q);
	assign sts.match     = pend_q && (rd_key_q == key_q);
	assign sts.snap_zero = (snap_n_q == '0);
	assign sts.snap_last = ((CNT_W'(pend_idx_q) + CNT_W'(1)) == snap_n_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		status_d = ST_OK;
		ekey_d   = '0;
		edata_d  = '0;
		evalid_d = 1'b0;
		ecnt_d   = '0;
		elast_d  = 1'b1;
		unique case (cmd.res)
			RES_OK_EMPTY: status_d = ST_OK;
			RES_FULL:     status_d = ST_FULL;
			RES_NOTFOUND: status_d = ST_NOT_FOUND;
			RES_ADD: begin
				ekey_d   = next_key_q;
				edata_d  = rec_q;
				evalid_d = 1'b1;
			end
			RES_RD_ENTRY: begin
				ekey_d   = rd_key_q;
				edata_d  = rd_data_q;
				evalid_d = 1'b1;
			end
			RES_SNAP: begin
				ekey_d   = rd_key_q;
				edata_d  = rd_data_q;
				evalid_d = 1'b1;
				ecnt_d   = snap_n_q;
				elast_d  = sts.snap_last;
			end
			default: status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status       <= status_d;
			entry_key    <= ekey_d;
			entry_data   <= edata_d;
			entry_valid  <= evalid_d;
			copied_count <= ecnt_d;
			last         <= elast_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
